// ===== design/fwbc_pkg.sv =====
package fwbc_pkg;

  localparam int DepthDefault = 16;
  localparam int KeyBitsDefault = 32;
  localparam int ValueBitsDefault = 32;

  localparam logic [1:0] ActSet   = 2'd0;
  localparam logic [1:0] ActGet   = 2'd1;
  localparam logic [1:0] ActFill  = 2'd2;
  localparam logic [1:0] ActFlush = 2'd3;

  localparam logic [2:0] KindSetDone  = 3'd0;
  localparam logic [2:0] KindGetAns   = 3'd1;
  localparam logic [2:0] KindStoreWr  = 3'd2;
  localparam logic [2:0] KindStoreRd  = 3'd3;
  localparam logic [2:0] KindFlushDone = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_EVICT,
    ST_FLUSH,
    ST_EMIT
  } eng_state_e;

endpackage

// ===== design/fifo_writeback_cache_core.sv =====
// FIFO-replacement write-back key/value cache.
// Input channel s_axis: one transfer is one access (set, get, fill, flush).
// Output channel m_axis: result transfers; tlast marks the final result of an
// access. Store write and store read requests go out on the same channel.
// Config: cfg_we_i writes entries_in_use (capacity) and empties the cache
// without write-back; write it only while idle.
// Order: an access is scanned one entry per cycle through the registered
// read port of the entry memory (ST_SCAN), then decided (ST_DECIDE), evicts
// the head entry if the cache is full (ST_EVICT) and puts its last result in
// the output register (ST_EMIT); the engine then goes back to idle before it
// takes the next access. A flush retires the entries from the head in turn.
// One access is worked on at a time; a two-entry queue in front keeps
// accepting while the engine works, until the queue is full.
// Reset empties the cache, capacity returns to 16 (clipped to DEPTH).
// When the receiver stalls, the result register holds and the engine waits.
module fifo_writeback_cache_core #(
  parameter int DEPTH = fwbc_pkg::DepthDefault,
  parameter int KEY_BITS = fwbc_pkg::KeyBitsDefault,
  parameter int VALUE_BITS = fwbc_pkg::ValueBitsDefault,
  localparam int IN_W = 3 + KEY_BITS + VALUE_BITS,
  localparam int IN_B = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W = KEY_BITS + VALUE_BITS + 1,
  localparam int OUT_B = ((OUT_W + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [4:0]       cfg_data_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // action, key, value, fill_found (low to high)
  input  logic [IN_B-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // out_key, out_value, found (low to high)
  output logic [OUT_B-1:0] m_axis_tdata,
  // kind
  output logic [2:0]       m_axis_tuser,
  output logic             m_axis_tlast
);
  import fwbc_pkg::*;

  logic            q_valid, q_ready;
  logic [IN_W-1:0] q_data;
  logic [KEY_BITS-1:0]   okey;
  logic [VALUE_BITS-1:0] oval;
  logic                  ofound;

  fwbc_front #(.W(IN_W)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_data_i(s_axis_tdata[IN_W-1:0]),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_data_o(q_data)
  );

  fwbc_engine #(.DEPTH(DEPTH), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_engine (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i,
    .q_valid_i(q_valid), .q_ready_o(q_ready),
    .q_action_i(q_data[1:0]),
    .q_key_i(q_data[2+:KEY_BITS]),
    .q_value_i(q_data[2+KEY_BITS+:VALUE_BITS]),
    .q_found_i(q_data[IN_W-1]),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_kind_o(m_axis_tuser), .out_key_o(okey), .out_value_o(oval),
    .out_found_o(ofound), .out_last_o(m_axis_tlast)
  );

  assign m_axis_tdata = OUT_B'({ofound, oval, okey});

  logic unused_pad;
  assign unused_pad = ^s_axis_tdata;

  // Hold a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  // Found is only set on get answers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[OUT_W-1] |-> m_axis_tuser == KindGetAns)
    else $error("found on non-answer");
endmodule

// ===== design/fwbc_front.sv =====
// Front part: accept input transfers and hold them in a two-entry queue.
module fwbc_front #(
  parameter int W = 67
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [W-1:0] in_data_i,
  output logic         q_valid_o,
  input  logic         q_ready_i,
  output logic [W-1:0] q_data_o
);
  logic [W-1:0] mem_q [2];
  logic         wr_q, rd_q;
  logic [1:0]   cnt_q;
  logic         push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_data_o   = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== design/fwbc_engine.sv =====
// Back part: scan, evict, insert, flush; one result register toward the output.
module fwbc_engine #(
  parameter int DEPTH = fwbc_pkg::DepthDefault,
  parameter int KEY_BITS = fwbc_pkg::KeyBitsDefault,
  parameter int VALUE_BITS = fwbc_pkg::ValueBitsDefault,
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [4:0]            cfg_data_i,
  input  logic                  q_valid_i,
  output logic                  q_ready_o,
  input  logic [1:0]            q_action_i,
  input  logic [KEY_BITS-1:0]   q_key_i,
  input  logic [VALUE_BITS-1:0] q_value_i,
  input  logic                  q_found_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            out_kind_o,
  output logic [KEY_BITS-1:0]   out_key_o,
  output logic [VALUE_BITS-1:0] out_value_o,
  output logic                  out_found_o,
  output logic                  out_last_o
);
  import fwbc_pkg::*;

  logic [KEY_BITS-1:0]   key_mem [DEPTH];
  logic [VALUE_BITS-1:0] val_mem [DEPTH];
  logic [DEPTH-1:0]      dirty_q, dirty_d;

  eng_state_e state_q, state_d;
  logic [IW-1:0] head_q, head_d, tail_q, tail_d, ptr_q, ptr_d, ridx_q, ridx_d;
  logic [CW-1:0] count_q, count_d, scan_q, scan_d, cap_q;
  logic [4:0]    eiu_q;
  logic [KEY_BITS-1:0]   pend_q, pend_d, akey_q, akey_d;
  logic [VALUE_BITS-1:0] aval_q, aval_d;
  logic [1:0]    act_q, act_d;
  logic          aff_q, aff_d, hit_q, hit_d, ins_q, ins_d;
  logic [IW-1:0] hidx_q, hidx_d;
  // registered read port
  logic [KEY_BITS-1:0]   rkey_q;
  logic [VALUE_BITS-1:0] rval_q;
  // output register
  logic ov_q, ov_d;
  logic [2:0] ok_q, ok_d;
  logic [KEY_BITS-1:0] okey_q, okey_d;
  logic [VALUE_BITS-1:0] oval_q, oval_d;
  logic of_q, of_d, ol_q, ol_d;
  logic wr_en;
  logic [IW-1:0] wr_idx;
  logic [KEY_BITS-1:0] wr_key;
  logic [VALUE_BITS-1:0] wr_val;
  logic wr_keyen;
  logic out_free;

  assign out_valid_o = ov_q;
  assign out_kind_o = ok_q;
  assign out_key_o = okey_q;
  assign out_value_o = oval_q;
  assign out_found_o = of_q;
  assign out_last_o = ol_q;
  assign out_free = !ov_q || out_ready_i;

  function automatic logic [IW-1:0] inc(input logic [IW-1:0] i, input logic [CW-1:0] c);
    logic [CW:0] n;
    n = {1'b0, {(CW-IW){1'b0}}, i} + 1'b1;
    inc = (n >= {1'b0, c}) ? '0 : n[IW-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    rkey_q <= key_mem[ridx_d];
    rval_q <= val_mem[ridx_d];
    if (wr_en) begin
      val_mem[wr_idx] <= wr_val;
      if (wr_keyen) key_mem[wr_idx] <= wr_key;
    end
  end

  always_comb begin
    state_d = state_q; head_d = head_q; tail_d = tail_q; ptr_d = ptr_q;
    count_d = count_q; scan_d = scan_q; pend_d = pend_q; akey_d = akey_q;
    aval_d = aval_q; act_d = act_q; aff_d = aff_q; hit_d = hit_q; ins_d = ins_q;
    hidx_d = hidx_q; dirty_d = dirty_q; ridx_d = ptr_q;
    ov_d = ov_q && !out_ready_i; ok_d = ok_q; okey_d = okey_q; oval_d = oval_q;
    of_d = of_q; ol_d = ol_q;
    wr_en = 1'b0; wr_idx = tail_q; wr_key = akey_q; wr_val = aval_q; wr_keyen = 1'b1;
    q_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          act_d = q_action_i; akey_d = q_key_i; aval_d = q_value_i; aff_d = q_found_i;
          if (q_action_i == ActFill) akey_d = pend_q;
          hit_d = 1'b0; scan_d = '0; ptr_d = head_q; ridx_d = head_q;
          state_d = (q_action_i == ActFlush) ? ST_FLUSH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        // rkey_q holds entry ptr_q; compare one entry per cycle
        if (cap_q == '0 || scan_q >= count_q) begin
          state_d = ST_DECIDE;
        end else if (rkey_q == akey_q) begin
          hit_d = 1'b1; hidx_d = ptr_q; state_d = ST_DECIDE;
        end else begin
          scan_d = scan_q + 1'b1;
          ptr_d = inc(ptr_q, cap_q); ridx_d = ptr_d;
        end
      end
      ST_DECIDE: begin
        ins_d = 1'b0;
        ridx_d = head_q;
        if (cap_q == '0) begin
          if (act_q == ActSet) begin
            if (out_free) begin
              ov_d = 1'b1; ok_d = KindStoreWr; okey_d = akey_q; oval_d = aval_q;
              of_d = 1'b0; ol_d = 1'b0; state_d = ST_EMIT;
            end
          end else begin
            state_d = ST_EMIT;
          end
        end else if (hit_q) begin
          if (act_q == ActSet) begin
            wr_en = 1'b1; wr_idx = hidx_q; wr_keyen = 1'b0; wr_val = aval_q;
            dirty_d[hidx_q] = 1'b1;
          end else if (act_q == ActGet) begin
            aval_d = rval_q; // rval_q holds hidx_q entry (ptr stopped there)
          end
          state_d = ST_EMIT;
        end else if (act_q == ActSet || (act_q == ActFill && aff_q)) begin
          ins_d = 1'b1;
          state_d = (count_q >= cap_q) ? ST_EVICT : ST_EMIT;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EVICT: begin
        // rkey_q/rval_q hold head entry
        if (!dirty_q[head_q] || out_free) begin
          if (dirty_q[head_q]) begin
            ov_d = 1'b1; ok_d = KindStoreWr; okey_d = rkey_q; oval_d = rval_q;
            of_d = 1'b0; ol_d = 1'b0;
          end
          dirty_d[head_q] = 1'b0;
          head_d = inc(head_q, cap_q);
          count_d = count_q - 1'b1;
          state_d = ST_EMIT;
        end
      end
      ST_FLUSH: begin
        ridx_d = head_q;
        if (cap_q == '0 || count_q == '0) begin
          dirty_d = '0; head_d = '0; tail_d = '0; count_d = '0;
          state_d = ST_EMIT;
        end else if (!dirty_q[head_q] || out_free) begin
          if (dirty_q[head_q]) begin
            ov_d = 1'b1; ok_d = KindStoreWr; okey_d = rkey_q; oval_d = rval_q;
            of_d = 1'b0; ol_d = 1'b0;
          end
          dirty_d[head_q] = 1'b0;
          head_d = inc(head_q, cap_q); ridx_d = head_d;
          count_d = count_q - 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ov_d = 1'b1; ol_d = 1'b1; of_d = 1'b0; okey_d = '0; oval_d = '0;
          state_d = ST_IDLE;
          case (act_q)
            ActSet: ok_d = KindSetDone;
            ActGet: begin
              okey_d = akey_q;
              if (hit_q && cap_q != '0) begin
                ok_d = KindGetAns; oval_d = aval_q; of_d = 1'b1;
              end else begin
                // a miss goes to the store; remember the key for the fill
                ok_d = KindStoreRd;
                pend_d = akey_q;
              end
            end
            ActFill: begin
              ok_d = KindGetAns; okey_d = akey_q;
              oval_d = aff_q ? aval_q : '0; of_d = aff_q;
            end
            default: ok_d = KindFlushDone;
          endcase
          if (ins_q && act_q != ActFlush) begin
            wr_en = 1'b1; wr_idx = tail_q; wr_key = akey_q; wr_val = aval_q;
            dirty_d[tail_q] = (act_q == ActSet);
            tail_d = inc(tail_q, cap_q);
            count_d = count_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    akey_q <= akey_d; aval_q <= aval_d; act_q <= act_d; aff_q <= aff_d;
    hidx_q <= hidx_d; okey_q <= okey_d; oval_q <= oval_d; ok_q <= ok_d;
    of_q <= of_d; ol_q <= ol_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; head_q <= '0; tail_q <= '0; ptr_q <= '0; ridx_q <= '0;
      count_q <= '0; scan_q <= '0; pend_q <= '0; hit_q <= 1'b0; ins_q <= 1'b0;
      dirty_q <= '0; ov_q <= 1'b0; eiu_q <= 5'd16;
      cap_q <= (DEPTH < 16) ? CW'(DEPTH) : CW'(16);
    end else begin
      state_q <= state_d; ptr_q <= ptr_d;
      ridx_q <= ridx_d; scan_q <= scan_d; pend_q <= pend_d;
      hit_q <= hit_d; ins_q <= ins_d; ov_q <= ov_d;
      if (cfg_we_i) begin
        eiu_q <= cfg_data_i;
        cap_q <= ({1'b0, cfg_data_i} > 6'(DEPTH)) ? CW'(DEPTH) : CW'(cfg_data_i);
        dirty_q <= '0; head_q <= '0; tail_q <= '0; count_q <= '0;
      end else begin
        dirty_q <= dirty_d; head_q <= head_d; tail_q <= tail_d; count_q <= count_d;
      end
    end
  end

  logic unused_ok;
  assign unused_ok = ^{eiu_q, ridx_q};
endmodule

// ===== tb/fifo_writeback_cache_checker.sv =====
module fifo_writeback_cache_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [71:0] m_axis_tdata,
  input  logic [2:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          err_count_o,
  output int          outstanding_o,
  output int          results_seen_o
);
  import fwbc_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] rkey;
    logic [31:0] rval;
    logic        found;
    logic        last;
  } cache_result_t;

  // Shadow copy of the cache contents.
  logic [31:0] shadow_key [16];
  logic [31:0] shadow_val [16];
  logic        shadow_dirty [16];
  int unsigned head_ptr, tail_ptr, fill_level, capacity;
  logic [31:0] miss_key;
  cache_result_t answers_due [$];

  function automatic int unsigned cap_now();
    return (capacity > 16) ? 16 : capacity;
  endfunction

  function automatic int find_slot(logic [31:0] k);
    int unsigned slot;
    for (int unsigned i = 0; i < fill_level; i++) begin
      slot = (head_ptr + i) % cap_now();
      if (shadow_key[slot] == k) return slot;
    end
    return -1;
  endfunction

  task automatic drop_all();
    for (int i = 0; i < 16; i++) shadow_dirty[i] = 1'b0;
    head_ptr = 0;
    tail_ptr = 0;
    fill_level = 0;
  endtask

  task automatic push_answer(logic [2:0] kind, logic [31:0] k, logic [31:0] v, logic f);
    answers_due.push_back('{kind: kind, rkey: k, rval: v, found: f, last: 1'b0});
  endtask

  // Retire the oldest entry, writing it back if dirty.
  task automatic retire_oldest();
    if (shadow_dirty[head_ptr])
      push_answer(KindStoreWr, shadow_key[head_ptr], shadow_val[head_ptr], 1'b0);
    shadow_dirty[head_ptr] = 1'b0;
    head_ptr = (head_ptr + 1) % cap_now();
    fill_level--;
  endtask

  task automatic place_entry(logic [31:0] k, logic [31:0] v, logic d);
    shadow_key[tail_ptr] = k;
    shadow_val[tail_ptr] = v;
    shadow_dirty[tail_ptr] = d;
    tail_ptr = (tail_ptr + 1) % cap_now();
    fill_level++;
  endtask

  task automatic predict_access(logic [1:0] act, logic [31:0] k, logic [31:0] v, logic ff);
    int slot;
    int unsigned cap;
    int before_n;
    cache_result_t tail_res;
    cap = cap_now();
    before_n = answers_due.size();
    case (act)
      ActSet: begin
        if (cap == 0) begin
          push_answer(KindStoreWr, k, v, 1'b0);
        end else begin
          slot = find_slot(k);
          if (slot >= 0) begin
            shadow_val[slot] = v;
            shadow_dirty[slot] = 1'b1;
          end else begin
            if (fill_level >= cap) retire_oldest();
            place_entry(k, v, 1'b1);
          end
        end
        push_answer(KindSetDone, '0, '0, 1'b0);
      end
      ActGet: begin
        slot = (cap == 0) ? -1 : find_slot(k);
        if (slot >= 0) begin
          push_answer(KindGetAns, k, shadow_val[slot], 1'b1);
        end else begin
          miss_key = k;
          push_answer(KindStoreRd, k, '0, 1'b0);
        end
      end
      ActFill: begin
        if (ff && cap != 0 && find_slot(miss_key) < 0) begin
          if (fill_level >= cap) retire_oldest();
          place_entry(miss_key, v, 1'b0);
        end
        push_answer(KindGetAns, miss_key, ff ? v : 32'd0, ff);
      end
      default: begin
        if (cap != 0)
          while (fill_level > 0) retire_oldest();
        drop_all();
        push_answer(KindFlushDone, '0, '0, 1'b0);
      end
    endcase
    if (answers_due.size() > before_n) begin
      tail_res = answers_due.pop_back();
      tail_res.last = 1'b1;
      answers_due.push_back(tail_res);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cache_result_t got, want;
    if (!rst_ni) begin
      drop_all();
      miss_key = '0;
      capacity = 16;
      answers_due.delete();
      err_count_o <= 0;
      results_seen_o <= 0;
    end else begin
      if (cfg_we_i) begin
        capacity = cfg_data_i;
        drop_all();
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_access(s_axis_tdata[1:0], s_axis_tdata[33:2], s_axis_tdata[65:34],
                       s_axis_tdata[66]);
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{kind: m_axis_tuser, rkey: m_axis_tdata[31:0], rval: m_axis_tdata[63:32],
                found: m_axis_tdata[64], last: m_axis_tlast};
        results_seen_o <= results_seen_o + 1;
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind=%0d key=%h val=%h f=%b l=%b",
                   $time, got.kind, got.rkey, got.rval, got.found, got.last);
          err_count_o <= err_count_o + 1;
        end else begin
          want = answers_due.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch, expected kind=%0d key=%h val=%h f=%b l=%b",
                     $time, want.kind, want.rkey, want.rval, want.found, want.last);
            $display("%0t:           actual   kind=%0d key=%h val=%h f=%b l=%b",
                     $time, got.kind, got.rkey, got.rval, got.found, got.last);
            err_count_o <= err_count_o + 1;
          end
        end
      end
    end
    outstanding_o <= answers_due.size();
  end

endmodule

// ===== tb/fifo_writeback_cache_core_test.sv =====
module fifo_writeback_cache_core_test;
  import fwbc_pkg::*;

  localparam int CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // action, key, value, fill_found (low to high)
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // out_key, out_value, found (low to high)
  logic [71:0] m_axis_tdata;
  // kind
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int          err_count, outstanding, results_seen;
  int          items_sent = 0;
  int unsigned cycle_count = 0;
  bit          idle_on = 1'b1;     // random gaps on both sides
  bit          hold_req = 1'b0;    // ask the receiver for a long hold-off
  bit          hold_done = 1'b0;   // the hold-off runs only once
  int          hold_left = 0;
  logic [31:0] key_pool [24];

  fifo_writeback_cache_core uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  fifo_writeback_cache_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .err_count_o(err_count), .outstanding_o(outstanding), .results_seen_o(results_seen)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: end the run once it has run past CycleLimit cycles.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_left <= 300;
      hold_done <= 1'b1;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(idle_on && $urandom_range(99) < 28);
    end
  end

  // Offer one access and hold it until the transfer; leave at a falling edge
  // with tvalid still high so back-to-back transfers need no gap.
  task automatic send_access(logic [1:0] act, logic [31:0] k, logic [31:0] v, logic ff);
    if (idle_on && $urandom_range(99) < 28) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, ff, v, k, act};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Drain, let the engine settle, then write the capacity.
  task automatic set_capacity(logic [4:0] cap);
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= cap;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_key();
    return ($urandom_range(99) < 10) ? $urandom() : key_pool[$urandom_range(23)];
  endfunction

  // Mostly get/fill pairs and sets on a small key pool so hits, evictions
  // and write-backs happen; the rest is lone fills and flushes.
  task automatic random_accesses(int n);
    int roll;
    logic [31:0] k;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      k = pick_key();
      if (roll < 40) begin
        send_access(ActSet, k, $urandom(), $urandom_range(1));
      end else if (roll < 80) begin
        send_access(ActGet, k, $urandom(), $urandom_range(1));
        if ($urandom_range(99) < 80)
          send_access(ActFill, $urandom(), $urandom(), $urandom_range(99) < 75);
      end else if (roll < 93) begin
        send_access(ActFill, $urandom(), $urandom(), $urandom_range(1));
      end else begin
        send_access(ActFlush, $urandom(), $urandom(), $urandom_range(1));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 22; i++) key_pool[i] = $urandom();
    key_pool[22] = 32'h0000_0000;
    key_pool[23] = 32'hffff_ffff;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: extremes, every action, hits, misses, odd fills, flushes.
    send_access(ActFlush, '0, '0, 1'b0);                      // flush while empty
    send_access(ActFill, 32'hffff_ffff, 32'h1234_5678, 1'b1); // fill with no get outstanding
    send_access(ActSet, 32'h0000_0000, 32'hffff_ffff, 1'b0);
    send_access(ActSet, 32'hffff_ffff, 32'h0000_0000, 1'b1);
    send_access(ActGet, 32'hffff_ffff, '0, 1'b0);             // hit
    send_access(ActSet, 32'hffff_ffff, 32'h5a5a_a5a5, 1'b0);  // update in place
    send_access(ActGet, 32'h0bad_f00d, '0, 1'b0);             // miss
    send_access(ActFill, '0, 32'hdead_beef, 1'b1);            // found, cached clean
    send_access(ActGet, 32'h0bad_f00d, '0, 1'b0);             // now a hit
    send_access(ActGet, 32'h7777_0000, '0, 1'b0);
    send_access(ActFill, '0, 32'hffff_ffff, 1'b0);            // not found
    send_access(ActGet, 32'h3333_3333, '0, 1'b0);
    send_access(ActSet, 32'h3333_3333, 32'h0101_0101, 1'b0);
    send_access(ActFill, '0, 32'h2222_2222, 1'b1);            // key already cached
    send_access(ActFlush, '0, '0, 1'b0);                      // write back dirty entries

    // Small capacity: evictions on set and on fill.
    set_capacity(5'd2);
    send_access(ActSet, 32'h1, 32'h11, 1'b0);
    send_access(ActGet, 32'h2, '0, 1'b0);
    send_access(ActFill, '0, 32'h22, 1'b1);
    send_access(ActSet, 32'h3, 32'h33, 1'b0);                 // evicts dirty entry
    send_access(ActGet, 32'h4, '0, 1'b0);
    send_access(ActFill, '0, 32'h44, 1'b1);                   // evicts the clean entry
    random_accesses(20);

    set_capacity(5'd0);   // pass-through
    send_access(ActSet, 32'hcafe_0001, 32'hffff_ffff, 1'b0);
    send_access(ActGet, 32'hcafe_0001, '0, 1'b0);
    send_access(ActFill, '0, 32'h600d_600d, 1'b1);
    send_access(ActFlush, '0, '0, 1'b0);
    random_accesses(15);

    set_capacity(5'd1);
    random_accesses(20);

    // No idling at all for a stretch, then a long receiver hold-off.
    set_capacity(5'd31);
    idle_on = 1'b0;
    random_accesses(30);
    hold_req <= 1'b1;
    random_accesses(25);
    hold_req <= 1'b0;
    idle_on = 1'b1;

    set_capacity(5'd16);
    random_accesses(40);
    set_capacity(5'd5);
    random_accesses(28);

    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    $display("covered %0d accesses and %0d results over capacities 16, 2, 0, 1, 31, 16, 5",
             items_sent, results_seen);
    $display("random stalls on both sides, a no-gap stretch and a 300-cycle output hold-off");
    if (err_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== fifo_writeback_cache_core.f =====
design/fwbc_pkg.sv
design/fwbc_front.sv
design/fwbc_engine.sv
design/fifo_writeback_cache_core.sv
tb/fifo_writeback_cache_checker.sv
tb/fifo_writeback_cache_core_test.sv
